// ===== rtl/i2da_pkg.sv =====
// i2da_pkg: types and constants for the integer to decimal ASCII converter.
// Used by i2da_cell, integer_to_decimal_ascii and i2da_checker.
package i2da_pkg;

    localparam int INPUT_WIDTH = 64;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef struct packed {
        logic [INPUT_WIDTH-1:0] value;
        logic                   is_negative_allowed;
    } request_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } result_t;

    // Operation applied by every digit cell in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STRIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/i2da_cell.sv =====
// i2da_cell: one BCD digit of the conversion chain.
// Depends on i2da_pkg (cell_op_t).
module i2da_cell
(
    input  logic              clk,
    input  i2da_pkg::cell_op_t op,
    input  logic              shift_bit,
    input  logic [3:0]        lower_digit,
    output logic              carry,
    output logic [3:0]        digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adjusted;

    // add-3 correction before the doubling step
    assign adjusted = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry    = adjusted[3];
    assign digit    = digit_reg;

    always_comb
    begin
        unique case (op)
            i2da_pkg::CELL_HOLD:   digit_next = digit_reg;
            i2da_pkg::CELL_CLEAR:  digit_next = 4'd0;
            i2da_pkg::CELL_DABBLE: digit_next = {adjusted[2:0], shift_bit};
            i2da_pkg::CELL_SHIFT:  digit_next = lower_digit;
            default:               digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== rtl/integer_to_decimal_ascii.sv =====
// integer_to_decimal_ascii: top level, control sequencer and row of digit cells.
// Depends on i2da_pkg and i2da_cell.
//
// One integer is converted at a time; busy stays high from the accepted start
// until the cycle after the last character. The low VALUE_WIDTH bits of the
// value are shifted, one bit per cycle, into a row of BCD digit cells. The row
// then shifts up one digit per cycle past leading zeros, and then the optional
// '-' and the digits are sent, most significant first. Each character appears
// on result for exactly one cycle with result_valid high; consecutive
// characters of one number come in consecutive cycles and the receiver must
// take each as it comes.
module integer_to_decimal_ascii
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  i2da_pkg::request_t request,
    output i2da_pkg::result_t  result,
    output logic               result_valid
);

    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    i2da_pkg::state_t   state_reg;
    i2da_pkg::state_t   state_next;
    i2da_pkg::cell_op_t cell_op;

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [DIG_CNT_W-1:0]   remain_reg;
    logic [DIG_CNT_W-1:0]   remain_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_neg;

    logic [3:0] digits [NUM_DIGITS];
    logic       carries [NUM_DIGITS];
    logic [3:0] top_digit;

    assign in_value  = request.value[VALUE_WIDTH-1:0];
    assign in_neg    = request.is_negative_allowed & in_value[VALUE_WIDTH-1];
    assign top_digit = digits[NUM_DIGITS-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_cell
            logic       sbit;
            logic [3:0] low_d;
            if (g == 0)
            begin : g_first
                assign sbit  = mag_reg[VALUE_WIDTH-1];
                assign low_d = 4'd0;
            end
            else
            begin : g_rest
                assign sbit  = carries[g-1];
                assign low_d = digits[g-1];
            end
            i2da_cell u_cell
            (
                .clk         (clk),
                .op          (cell_op),
                .shift_bit   (sbit),
                .lower_digit (low_d),
                .carry       (carries[g]),
                .digit       (digits[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        remain_next  = remain_reg;
        cell_op      = i2da_pkg::CELL_HOLD;
        busy         = 1'b1;
        result_valid = 1'b0;
        result.character = i2da_pkg::ASCII_ZERO + {4'd0, top_digit};
        result.last      = (remain_reg == DIG_CNT_W'(1));

        unique case (state_reg)
            i2da_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    mag_next     = in_neg ? (~in_value + 1'b1) : in_value;
                    neg_next     = in_neg;
                    bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
                    remain_next  = DIG_CNT_W'(NUM_DIGITS);
                    cell_op      = i2da_pkg::CELL_CLEAR;
                    state_next   = i2da_pkg::ST_CONVERT;
                end
            end
            i2da_pkg::ST_CONVERT:
            begin
                cell_op      = i2da_pkg::CELL_DABBLE;
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                    state_next = i2da_pkg::ST_STRIP;
            end
            i2da_pkg::ST_STRIP:
            begin
                // drop leading zeros, always keep one digit
                if (top_digit == 4'd0 && remain_reg != DIG_CNT_W'(1))
                begin
                    cell_op     = i2da_pkg::CELL_SHIFT;
                    remain_next = remain_reg - DIG_CNT_W'(1);
                end
                else if (neg_reg)
                    state_next = i2da_pkg::ST_SIGN;
                else
                    state_next = i2da_pkg::ST_EMIT;
            end
            i2da_pkg::ST_SIGN:
            begin
                result_valid     = 1'b1;
                result.character = i2da_pkg::ASCII_MINUS;
                result.last      = 1'b0;
                state_next       = i2da_pkg::ST_EMIT;
            end
            i2da_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                cell_op      = i2da_pkg::CELL_SHIFT;
                remain_next  = remain_reg - DIG_CNT_W'(1);
                if (remain_reg == DIG_CNT_W'(1))
                    state_next = i2da_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = i2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= i2da_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            remain_reg  <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== rtl/i2da_checker.sv =====
// i2da_checker: port-level assertions for integer_to_decimal_ascii, bound to the top.
// Depends on i2da_pkg.
module i2da_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input i2da_pkg::result_t  result,
    input logic               result_valid
);

    // a conversion never finishes in the accepting cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted start");

    a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat while idle");

    // characters of one number come without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside number text");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !busy && !result_valid)
        else $error("block not idle after last beat");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.character == i2da_pkg::ASCII_MINUS) ||
                         (result.character >= i2da_pkg::ASCII_ZERO &&
                          result.character <= i2da_pkg::ASCII_ZERO + 8'd9))
        else $error("character out of range");

endmodule

bind integer_to_decimal_ascii i2da_checker u_i2da_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for integer_to_decimal_ascii: drives numbers and checks the decimal text.
// Depends on i2da_pkg and the RTL top level; a small scoreboard predicts each character.
module testbench;

    localparam int VALUE_WIDTH    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 120;

    class text_scoreboard;
        i2da_pkg::result_t expected_chars[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Expected decimal text of one accepted number
        function void note_number(i2da_pkg::request_t r);
            logic [63:0]       mask;
            logic [63:0]       v;
            logic [63:0]       mag;
            logic              neg;
            logic [7:0]        digits[$];
            i2da_pkg::result_t c;
            mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
            v    = r.value & mask;
            neg  = r.is_negative_allowed && v[VALUE_WIDTH-1];
            mag  = neg ? ((~v + 64'd1) & mask) : v;
            // digits collected least significant first
            do
            begin
                digits.push_back(i2da_pkg::ASCII_ZERO + 8'(mag % 64'd10));
                mag = mag / 64'd10;
            end
            while (mag != 0);
            if (neg)
            begin
                c.character = i2da_pkg::ASCII_MINUS;
                c.last      = 1'b0;
                expected_chars.push_back(c);
            end
            for (int i = digits.size() - 1; i >= 0; i--)
            begin
                c.character = digits[i];
                c.last      = (i == 0);
                expected_chars.push_back(c);
            end
        endfunction

        task check_result(i2da_pkg::result_t got);
            i2da_pkg::result_t want;
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          got.character, got.last));
                return;
            end
            want = expected_chars.pop_front();
            if (got.character !== want.character)
                report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                          got.character, want.character));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                          got.last, want.last, want.character));
        endtask

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    i2da_pkg::request_t request;
    i2da_pkg::result_t  result;
    logic               result_valid;

    text_scoreboard board;
    int             stall_cycles;

    integer_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid)
    );

    always #6 clk = ~clk;

    function automatic i2da_pkg::request_t make_request(logic [63:0] v, logic s);
        i2da_pkg::request_t r;
        r.value               = v;
        r.is_negative_allowed = s;
        return r;
    endfunction

    // Present one number, optionally after a gap, and hold it until accepted.
    // The gap starts once the block is idle so that it really sees no start.
    task send_number(i2da_pkg::request_t r, int idle_pct);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            while (busy)
                @(negedge clk);
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        start   <= 1'b1;
        request <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        board.note_number(r);
    endtask

    function automatic i2da_pkg::request_t random_request();
        logic [63:0] v;
        logic [63:0] p;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            1: v = v >> $urandom_range(63);
            2: v = ~(v >> $urandom_range(63)) + 64'd1;
            default:
            begin
                p = 64'd1;
                repeat ($urandom_range(19)) p = p * 64'd10;
                v = p + 64'($urandom_range(2)) - 64'd1;
            end
        endcase
        return make_request(v, 1'($urandom_range(1)));
    endfunction

    always @(posedge clk)
        if (rst_n && result_valid)
            board.check_result(result);

    // Ends the run if neither an input nor a character moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("integer_to_decimal_ascii regression: fail");
            $finish;
        end
    end

    initial
    begin
        int idle_phase[4];
        board        = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        stall_cycles = 0;
        idle_phase   = '{0, 84, 29, 0};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero, single digits, digit-count boundaries, sign extremes
        send_number(make_request(64'd0, 1'b0), 0);
        send_number(make_request(64'd0, 1'b1), 0);
        send_number(make_request(64'd1, 1'b0), 0);
        send_number(make_request(64'd9, 1'b1), 0);
        send_number(make_request(64'd10, 1'b0), 0);
        send_number(make_request(64'd99, 1'b0), 0);
        send_number(make_request(64'd100, 1'b1), 0);
        send_number(make_request({64{1'b1}}, 1'b0), 0);
        send_number(make_request({64{1'b1}}, 1'b1), 0);
        send_number(make_request(64'h8000_0000_0000_0000, 1'b1), 0);
        send_number(make_request(64'h8000_0000_0000_0000, 1'b0), 0);
        send_number(make_request(64'h8000_0000_0000_0001, 1'b1), 0);
        send_number(make_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b1), 0);
        send_number(make_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b0), 0);
        send_number(make_request(64'd10000000000000000000, 1'b0), 0);
        send_number(make_request(64'd9999999999999999999, 1'b0), 0);
        send_number(make_request(64'd1000000000000000000, 1'b1), 0);
        send_number(make_request(-64'sd10, 1'b1), 0);
        send_number(make_request(64'd12345678901234567890, 1'b0), 0);
        send_number(make_request(64'h5555_5555_5555_5555, 1'b1), 0);
        send_number(make_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b1), 0);
        send_number(make_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0), 0);

        foreach (idle_phase[p])
            repeat (88) send_number(random_request(), idle_phase[p]);

        @(negedge clk);
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("integer_to_decimal_ascii regression: pass");
        else
            $display("integer_to_decimal_ascii regression: fail");
        $finish;
    end
endmodule
